@@ design/wsot_pkg.sv @@
// ----------------------------------------------------------------------------
// wsot_pkg
// Shared types and constants for the weekly schedule output timer: field
// widths, calendar constants, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wsot_pkg;

  localparam int DAYS          = 7;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOUR_PER_DAY  = 24;
  localparam int SEC_PER_HOUR  = 3600;

  localparam int OP_W      = 2;
  localparam int DAY_W     = 3;
  localparam int SLOT_W    = 3;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int DUR_W     = 17;
  localparam int TPS_W     = 11;
  localparam int SUB_W     = 10;
  localparam int TOD_W     = 17;
  localparam int SPAN_W    = 18;
  localparam int TICKS_W   = 27;

  localparam logic [TPS_W-1:0] TPS_MAX   = 11'd1024;
  localparam logic [TPS_W-1:0] TPS_RESET = 11'd8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_WRITE_SLOT = 2'd1,
    OP_SET_CLOCK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DAY_W-1:0]  weekday;
    logic [SLOT_W-1:0] slot;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [DUR_W-1:0]  duration_seconds;
  } in_item_t;

  typedef struct packed {
    logic                output_on;
    logic [DAY_W-1:0]    now_weekday;
    logic [HOUR_W-1:0]   now_hour;
    logic [MIN_W-1:0]    now_minute;
    logic [SEC_W-1:0]    now_second;
    logic [TICKS_W-1:0]  remaining_ticks;
  } out_item_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [DUR_W-1:0]  duration;
  } slot_entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_NOW,
    S_READ,
    S_START,
    S_CHECK,
    S_LOAD,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic exec;
    logic scan_init;
    logic scan_rd;
    logic scan_start;
    logic scan_check;
    logic scan_next;
    logic scan_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic hit;
    logic slot_last;
  } dp_status_t;

endpackage

@@ design/wsot_if.sv @@
// ----------------------------------------------------------------------------
// wsot_if
// Valid/ready channels of the weekly schedule output timer: the operation
// channel into the block and the status result channel out of it.
// ----------------------------------------------------------------------------
interface wsot_in_if import wsot_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DAY_W-1:0]  weekday;
  logic [SLOT_W-1:0] slot;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [SEC_W-1:0]  second;
  logic [DUR_W-1:0]  duration_seconds;

  modport source (
    output valid, operation, weekday, slot, hour, minute, second, duration_seconds,
    input  ready
  );
  modport sink (
    input  valid, operation, weekday, slot, hour, minute, second, duration_seconds,
    output ready
  );
endinterface

interface wsot_out_if import wsot_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               output_on;
  logic [DAY_W-1:0]   now_weekday;
  logic [HOUR_W-1:0]  now_hour;
  logic [MIN_W-1:0]   now_minute;
  logic [SEC_W-1:0]   now_second;
  logic [TICKS_W-1:0] remaining_ticks;

  modport source (
    output valid, output_on, now_weekday, now_hour, now_minute, now_second,
           remaining_ticks,
    input  ready
  );
  modport sink (
    input  valid, output_on, now_weekday, now_hour, now_minute, now_second,
           remaining_ticks,
    output ready
  );
endinterface

@@ design/weekly_schedule_output_timer.sv @@
// ----------------------------------------------------------------------------
// weekly_schedule_output_timer
// Weekly programmable timer switch. After reset the block first clears its
// slot memory of 7*SLOTS_PER_DAY entries (56 by default), one entry a cycle,
// and takes no transaction until that pass is done; cfg writes are taken at
// any time. It then works one transaction at a time: a slot write, a clock set
// or a tick that starts no scan goes through the capture, execute and finish
// steps to a registered result. A tick that starts a new second and leaves the
// output off scans the day's slots through the read port of the slot memory,
// with a read, a start and a check step per slot, stopping at the first match;
// on a match a load step sets the countdown from the multiply. The next
// transaction is taken while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module weekly_schedule_output_timer import wsot_pkg::*; #(
  parameter int SLOTS_PER_DAY = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  wsot_in_if.sink          in_if,
  wsot_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [TPS_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t st;
  in_item_t   in_item;
  out_item_t  out_item;

  assign in_item.operation        = in_if.operation;
  assign in_item.weekday          = in_if.weekday;
  assign in_item.slot             = in_if.slot;
  assign in_item.hour             = in_if.hour;
  assign in_item.minute           = in_if.minute;
  assign in_item.second           = in_if.second;
  assign in_item.duration_seconds = in_if.duration_seconds;

  wsot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .st        (st),
    .cmd       (cmd)
  );

  wsot_dp #(
    .SLOTS_PER_DAY (SLOTS_PER_DAY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_item  (out_item)
  );

  assign out_if.output_on       = out_item.output_on;
  assign out_if.now_weekday     = out_item.now_weekday;
  assign out_if.now_hour        = out_item.now_hour;
  assign out_if.now_minute      = out_item.now_minute;
  assign out_if.now_second      = out_item.now_second;
  assign out_if.remaining_ticks = out_item.remaining_ticks;

endmodule

@@ design/wsot_dp.sv @@
// ----------------------------------------------------------------------------
// wsot_dp
// Datapath: calendar clock, subsecond counter, off countdown, slot memory
// with its clearing counter, scan registers and the result register.
// ----------------------------------------------------------------------------
module wsot_dp import wsot_pkg::*; #(
  parameter int SLOTS_PER_DAY = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TPS_W-1:0] cfg_wdata,
  input  in_item_t         in_item,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       st,
  output out_item_t        out_item
);

  localparam int DEPTH = DAYS * SLOTS_PER_DAY;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam logic [6:0] SLOT_LIMIT = 7'(SLOTS_PER_DAY);

  function automatic logic [TOD_W-1:0] tod_sec(input logic [HOUR_W-1:0] h,
                                               input logic [MIN_W-1:0]  m,
                                               input logic [SEC_W-1:0]  s);
    return TOD_W'(h) * TOD_W'(SEC_PER_HOUR) + TOD_W'(m) * TOD_W'(SEC_PER_MIN)
           + TOD_W'(s);
  endfunction

  logic [TPS_W-1:0]   tps_r;
  logic [SUB_W-1:0]   sub_r;
  logic [DAY_W-1:0]   day_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;
  logic               active_r;
  logic [TICKS_W-1:0] cd_r;
  logic [AW-1:0]      clr_addr_r;
  logic [SW-1:0]      slot_idx_r;

  in_item_t           it_r;
  slot_entry_t        rd_data_r;
  logic [TOD_W-1:0]   now_r;
  logic [TOD_W-1:0]   start_r;
  logic [DUR_W-1:0]   dur_r;
  logic [SPAN_W-1:0]  diff_r;
  out_item_t          out_r;

  slot_entry_t        mem [DEPTH];

  logic [TPS_W-1:0]   tps_eff;
  logic [TICKS_W-1:0] cd_dec;
  logic               active_tick;
  logic [TPS_W-1:0]   sub_inc;
  logic               new_sec;
  logic [DAY_W-1:0]   day_adv;
  logic [HOUR_W-1:0]  hour_adv;
  logic [MIN_W-1:0]   min_adv;
  logic [SEC_W-1:0]   sec_adv;
  logic               wr_ok;
  logic               set_ok;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  slot_entry_t        mem_wdata;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [SPAN_W-1:0]  span_end;
  logic [SPAN_W+TPS_W-1:0] prod;

  // zero acts as one, anything past the maximum saturates
  always_comb begin
    if (tps_r == '0) begin
      tps_eff = TPS_W'(1);
    end else if (tps_r > TPS_MAX) begin
      tps_eff = TPS_MAX;
    end else begin
      tps_eff = tps_r;
    end
  end

  // countdown first, then the subsecond count
  assign cd_dec      = (active_r && cd_r != '0) ? cd_r - TICKS_W'(1) : cd_r;
  assign active_tick = active_r && (cd_dec != '0);
  assign sub_inc     = TPS_W'(sub_r) + TPS_W'(1);
  assign new_sec     = sub_inc >= tps_eff;

  always_comb begin
    day_adv  = day_r;
    hour_adv = hour_r;
    min_adv  = min_r;
    sec_adv  = sec_r + SEC_W'(1);
    if (sec_adv >= SEC_W'(SEC_PER_MIN)) begin
      sec_adv = '0;
      min_adv = min_r + MIN_W'(1);
      if (min_adv >= MIN_W'(MIN_PER_HOUR)) begin
        min_adv  = '0;
        hour_adv = hour_r + HOUR_W'(1);
        if (hour_adv >= HOUR_W'(HOUR_PER_DAY)) begin
          hour_adv = '0;
          day_adv  = day_r + DAY_W'(1);
          if (day_adv >= DAY_W'(DAYS)) begin
            day_adv = '0;
          end
        end
      end
    end
  end

  assign wr_ok  = (it_r.weekday < DAY_W'(DAYS)) && ({4'd0, it_r.slot} < SLOT_LIMIT);
  assign set_ok = (it_r.weekday < DAY_W'(DAYS)) && (it_r.hour < HOUR_W'(HOUR_PER_DAY))
                  && (it_r.minute < MIN_W'(MIN_PER_HOUR))
                  && (it_r.second < SEC_W'(SEC_PER_MIN));

  assign wr_addr   = AW'(it_r.weekday) * AW'(SLOTS_PER_DAY) + AW'(it_r.slot);
  assign rd_addr   = AW'(day_r) * AW'(SLOTS_PER_DAY) + AW'(slot_idx_r);
  assign mem_we    = cmd.clr_wr || (cmd.exec && it_r.operation == OP_WRITE_SLOT && wr_ok);
  assign mem_waddr = cmd.clr_wr ? clr_addr_r : wr_addr;
  assign mem_wdata = cmd.clr_wr ? slot_entry_t'('0)
                                : slot_entry_t'{hour:     it_r.hour,
                                                minute:   it_r.minute,
                                                second:   it_r.second,
                                                duration: it_r.duration_seconds};

  assign span_end = SPAN_W'(start_r) + SPAN_W'(dur_r);
  assign prod     = (SPAN_W+TPS_W)'(diff_r) * (SPAN_W+TPS_W)'(tps_eff);

  assign st.clear_last = clr_addr_r == AW'(DEPTH - 1);
  assign st.need_scan  = (it_r.operation == OP_TICK) && new_sec && !active_tick;
  assign st.hit        = (now_r >= start_r) && (SPAN_W'(now_r) < span_end);
  assign st.slot_last  = slot_idx_r == SW'(SLOTS_PER_DAY - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r      <= TPS_RESET;
      sub_r      <= '0;
      day_r      <= '0;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
      active_r   <= 1'b0;
      cd_r       <= '0;
      clr_addr_r <= '0;
      slot_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (cmd.clr_wr && !st.clear_last) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.exec) begin
        case (it_r.operation)
          OP_TICK: begin
            cd_r     <= cd_dec;
            active_r <= active_tick;
            if (new_sec) begin
              sub_r  <= '0;
              day_r  <= day_adv;
              hour_r <= hour_adv;
              min_r  <= min_adv;
              sec_r  <= sec_adv;
            end else begin
              sub_r <= sub_inc[SUB_W-1:0];
            end
          end
          OP_SET_CLOCK: begin
            if (set_ok) begin
              sub_r  <= '0;
              day_r  <= it_r.weekday;
              hour_r <= it_r.hour;
              min_r  <= it_r.minute;
              sec_r  <= it_r.second;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_init) begin
        slot_idx_r <= '0;
      end
      if (cmd.scan_next) begin
        slot_idx_r <= slot_idx_r + SW'(1);
      end
      if (cmd.scan_load) begin
        cd_r     <= prod[TICKS_W-1:0];
        active_r <= prod[TICKS_W-1:0] != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_r <= in_item;
    end
    if (cmd.scan_init) begin
      now_r <= tod_sec(hour_r, min_r, sec_r);
    end
    if (cmd.scan_start) begin
      start_r <= tod_sec(rd_data_r.hour, rd_data_r.minute, rd_data_r.second);
      dur_r   <= rd_data_r.duration;
    end
    if (cmd.scan_check) begin
      diff_r <= span_end - SPAN_W'(now_r);
    end
    if (cmd.out_load) begin
      out_r.output_on       <= active_r;
      out_r.now_weekday     <= day_r;
      out_r.now_hour        <= hour_r;
      out_r.now_minute      <= min_r;
      out_r.now_second      <= sec_r;
      out_r.remaining_ticks <= active_r ? cd_r : '0;
    end
  end

  assign out_item = out_r;

  a_active_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> cd_r != '0)
    else $error("output active with an empty countdown");

  a_clock_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r < SEC_W'(SEC_PER_MIN)) && (min_r < MIN_W'(MIN_PER_HOUR))
    && (hour_r < HOUR_W'(HOUR_PER_DAY)) && (day_r < DAY_W'(DAYS)))
    else $error("calendar clock out of range");

endmodule

@@ design/wsot_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsot_ctrl
// Controller: sequences the slot memory clearing pass, one operation at a
// time, the slot scan of a new second and the hand-off to the result register.
// ----------------------------------------------------------------------------
module wsot_ctrl import wsot_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = st.need_scan ? S_NOW : S_FINISH;
      end
      S_NOW: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_CHECK;
      end
      S_CHECK: begin
        cmd.scan_check = 1'b1;
        if (st.hit) begin
          state_nxt = S_LOAD;
        end else if (st.slot_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_LOAD: begin
        cmd.scan_load = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in progress");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result presented outside the finish step");

endmodule
